// ===== hw/rtl/apts_pkg.sv =====
package apts_pkg;

  localparam int NUM_TASKS      = 16;
  localparam int TASK_W         = 4;
  localparam int REALTIME_LEVEL = 6;
  localparam int PRIORITY_CAP   = 255;

  localparam logic [1:0] OP_CFG   = 2'd0;
  localparam logic [1:0] OP_SCHED = 2'd1;
  localparam logic [1:0] OP_EXEC  = 2'd2;
  localparam logic [1:0] OP_SYS   = 2'd3;

  localparam logic [1:0] REG_GUARD_MIN    = 2'd0;
  localparam logic [1:0] REG_GUARD_MAX    = 2'd1;
  localparam logic [1:0] REG_GUARD_MARGIN = 2'd2;
  localparam logic [1:0] REG_MIN_PERIOD   = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  task_index;
    logic        use_current;
    logic [31:0] period_us;
    logic [3:0]  base_priority;
    logic        enable_flag;
    logic        event_kind;
    logic [31:0] now_time;
    logic [15:0] event_mask;
    logic [31:0] run_time;
  } in_t;

  typedef struct packed {
    logic        chosen_valid;
    logic [3:0]  chosen_task;
    logic [31:0] delta_time;
    logic [4:0]  waiting_count;
    logic [10:0] load_percent;
    logic [16:0] guard_interval;
  } out_t;

  typedef struct packed {
    logic [15:0] guard_min;
    logic [15:0] guard_max;
    logic [15:0] guard_margin;
    logic [15:0] min_period;
  } cfg_t;

endpackage

// ===== hw/rtl/apts_front.sv =====
module apts_front import apts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic q_valid,
  input  logic q_ready,
  output in_t  q_item
);

  in_t        slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= in_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hw/rtl/apts_back.sv =====
module apts_back import apts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic q_valid,
  output logic q_ready,
  input  in_t  q_item,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CFG   = 4'd1;
  localparam logic [3:0] S_TTN   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_UPD   = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_EXEC  = 4'd7;
  localparam logic [3:0] S_LOADW = 4'd8;
  localparam logic [3:0] S_GMAX  = 4'd9;
  localparam logic [3:0] S_GSET  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam logic [1:0] K_NONE  = 2'd0;
  localparam logic [1:0] K_SIG   = 2'd1;
  localparam logic [1:0] K_EVDIV = 2'd2;
  localparam logic [1:0] K_TDIV  = 2'd3;

  logic [31:0]       period_a [NUM_TASKS];
  logic [3:0]        level_a  [NUM_TASKS];
  logic              en_a     [NUM_TASKS];
  logic              evk_a    [NUM_TASKS];
  logic [31:0]       run_at_a [NUM_TASKS];
  logic [31:0]       sig_at_a [NUM_TASKS];
  logic [7:0]        dyn_a    [NUM_TASKS];
  logic [31:0]       delta_a  [NUM_TASKS];
  logic [31:0]       avg_a    [NUM_TASKS];
  logic [31:0]       maxe_a   [NUM_TASKS];
  logic [31:0]       tot_a    [NUM_TASKS];

  logic [3:0]        state_r;
  in_t               item_r;
  logic [TASK_W-1:0] idx_r;
  logic [TASK_W-1:0] cur_r;
  logic              curv_r;
  logic [TASK_W-1:0] sel_r;
  logic [7:0]        best_r;
  logic              found_r;
  logic              cv_r;
  logic [31:0]       ttn_r;
  logic [4:0]        wait_r;
  logic [1:0]        kind_r;
  logic [31:0]       mx_r;
  logic [16:0]       guard_r;
  logic [31:0]       wsum_r;
  logic [31:0]       pass_r;
  logic [10:0]       load_r;
  logic              div_sys_r;
  logic [32:0]       rem_r;
  logic [39:0]       dvd_r;
  logic [39:0]       quo_r;
  logic [31:0]       dvs_r;
  logic [5:0]        cnt_r;
  logic              out_valid_r;
  out_t              out_r;

  logic [TASK_W-1:0] ix;
  logic [TASK_W-1:0] cfg_t_ix;
  logic              last;
  logic [31:0]       due;
  logic [31:0]       diff;
  logic [31:0]       left;
  logic [32:0]       shifted;
  logic              take;
  logic [31:0]       age;
  logic [35:0]       prod;
  logic [7:0]        pri;
  logic [7:0]        newdyn;
  logic              bump;
  logic              can;
  logic [36:0]       avg_sum;
  logic [38:0]       wsum100;
  logic [15:0]       clamp;
  logic [31:0]       pdiv;

  assign q_ready   = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cfg_t_ix = item_r.use_current ? cur_r : item_r.task_index;
  always_comb begin
    case (state_r)
      S_CFG:                  ix = cfg_t_ix;
      S_FIN:                  ix = sel_r;
      S_EXEC, S_OUT:          ix = cur_r;
      default:                ix = idx_r;
    endcase
  end

  assign last = (idx_r == TASK_W'(NUM_TASKS - 1));
  assign due  = run_at_a[ix] + period_a[ix];
  assign diff = item_r.now_time - due;
  assign left = due - item_r.now_time;
  assign pdiv = (period_a[ix] == 32'd0) ? 32'd1 : period_a[ix];

  assign shifted = {rem_r[31:0], dvd_r[39]};
  assign take    = (shifted >= {1'b0, dvs_r});

  always_comb begin
    case (kind_r)
      K_EVDIV: age = (quo_r[31:0] == 32'hFFFF_FFFF) ? quo_r[31:0] : quo_r[31:0] + 32'd1;
      K_TDIV:  age = quo_r[31:0];
      K_SIG:   age = 32'd1;
      default: age = 32'd0;
    endcase
  end

  assign prod = 36'(level_a[ix]) * 36'(age);
  assign pri  = (prod >= 36'(PRIORITY_CAP)) ? 8'(PRIORITY_CAP) : 8'(prod + 36'd1);
  assign bump = (kind_r == K_EVDIV) || (kind_r == K_SIG) ||
                ((kind_r == K_TDIV) && (age != 32'd0));
  assign newdyn = bump ? pri : dyn_a[ix];
  assign can = (ttn_r > {15'd0, guard_r}) || (age > 32'd1) ||
               (level_a[ix] == 4'(REALTIME_LEVEL));

  assign avg_sum = ({5'd0, avg_a[ix]} << 5) - {5'd0, avg_a[ix]} +
                   {5'd0, item_r.run_time};
  assign wsum100 = 39'(wsum_r) * 39'd100;

  always_comb begin
    if (mx_r < {16'd0, cfg.guard_min}) clamp = cfg.guard_min;
    else if (mx_r > {16'd0, cfg.guard_max}) clamp = cfg.guard_max;
    else clamp = mx_r[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        period_a[i] <= 32'd100;
        level_a[i]  <= 4'd0;
        en_a[i]     <= 1'b0;
        evk_a[i]    <= 1'b0;
        run_at_a[i] <= 32'd0;
        sig_at_a[i] <= 32'd0;
        dyn_a[i]    <= 8'd0;
        delta_a[i]  <= 32'd0;
        avg_a[i]    <= 32'd0;
        maxe_a[i]   <= 32'd0;
        tot_a[i]    <= 32'd0;
      end
      state_r     <= S_IDLE;
      cur_r       <= '0;
      curv_r      <= 1'b0;
      guard_r     <= 17'd300;
      wsum_r      <= 32'd0;
      pass_r      <= 32'd0;
      load_r      <= 11'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            item_r  <= q_item;
            cv_r    <= 1'b0;
            wait_r  <= 5'd0;
            idx_r   <= '0;
            ttn_r   <= 32'hFFFF_FFFF;
            best_r  <= 8'd0;
            found_r <= 1'b0;
            mx_r    <= 32'd0;
            case (q_item.opcode)
              OP_CFG:   state_r <= S_CFG;
              OP_SCHED: state_r <= S_TTN;
              OP_EXEC:  state_r <= S_EXEC;
              default: begin
                if (pass_r != 32'd0) begin
                  dvd_r     <= {wsum100, 1'b0};
                  dvs_r     <= pass_r;
                  rem_r     <= 33'd0;
                  cnt_r     <= 6'd39;
                  div_sys_r <= 1'b1;
                  state_r   <= S_DIV;
                end else begin
                  state_r <= S_GMAX;
                end
              end
            endcase
          end
        end
        S_CFG: begin
          if (!item_r.use_current || curv_r) begin
            period_a[ix] <= (item_r.period_us < {16'd0, cfg.min_period}) ?
                            {16'd0, cfg.min_period} : item_r.period_us;
            level_a[ix]  <= item_r.base_priority;
            en_a[ix]     <= item_r.enable_flag;
            evk_a[ix]    <= item_r.event_kind;
          end
          state_r <= S_OUT;
        end
        S_TTN: begin
          if (level_a[ix] == 4'(REALTIME_LEVEL)) begin
            if (!diff[31]) ttn_r <= 32'd0;
            else if (left < ttn_r) ttn_r <= left;
          end
          idx_r <= idx_r + 1'b1;
          if (last) state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (!en_a[ix]) begin
            idx_r <= idx_r + 1'b1;
            if (last) state_r <= S_FIN;
          end else begin
            rem_r     <= 33'd0;
            cnt_r     <= 6'd32;
            div_sys_r <= 1'b0;
            dvs_r     <= pdiv;
            if (evk_a[ix]) begin
              if (dyn_a[ix] != 8'd0) begin
                kind_r  <= K_EVDIV;
                dvd_r   <= {item_r.now_time - sig_at_a[ix], 8'd0};
                state_r <= S_DIV;
              end else if (item_r.event_mask[ix]) begin
                kind_r  <= K_SIG;
                state_r <= S_UPD;
              end else begin
                kind_r  <= K_NONE;
                state_r <= S_UPD;
              end
            end else begin
              kind_r  <= K_TDIV;
              dvd_r   <= {item_r.now_time - run_at_a[ix], 8'd0};
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_r <= take ? shifted - {1'b0, dvs_r} : shifted;
          quo_r <= {quo_r[38:0], take};
          dvd_r <= {dvd_r[38:0], 1'b0};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) state_r <= div_sys_r ? S_LOADW : S_UPD;
        end
        S_UPD: begin
          dyn_a[ix] <= newdyn;
          if (kind_r == K_SIG) sig_at_a[ix] <= item_r.now_time;
          if (bump) wait_r <= wait_r + 5'd1;
          if (can && newdyn > best_r) begin
            best_r  <= newdyn;
            sel_r   <= idx_r;
            found_r <= 1'b1;
          end
          idx_r   <= idx_r + 1'b1;
          state_r <= last ? S_FIN : S_SCAN;
        end
        S_FIN: begin
          pass_r <= pass_r + 32'd1;
          wsum_r <= wsum_r + 32'(wait_r);
          cv_r   <= found_r;
          curv_r <= found_r;
          cur_r  <= found_r ? sel_r : '0;
          if (found_r) begin
            delta_a[ix]  <= item_r.now_time - run_at_a[ix];
            run_at_a[ix] <= item_r.now_time;
            dyn_a[ix]    <= 8'd0;
          end
          state_r <= S_OUT;
        end
        S_EXEC: begin
          if (curv_r) begin
            avg_a[ix] <= avg_sum[36:5];
            tot_a[ix] <= tot_a[ix] + item_r.run_time;
            if (item_r.run_time > maxe_a[ix]) maxe_a[ix] <= item_r.run_time;
          end
          state_r <= S_OUT;
        end
        S_LOADW: begin
          load_r  <= (quo_r[38:0] > 39'd2047) ? 11'd2047 : quo_r[10:0];
          pass_r  <= 32'd0;
          wsum_r  <= 32'd0;
          state_r <= S_GMAX;
        end
        S_GMAX: begin
          if (level_a[ix] != 4'(REALTIME_LEVEL) && avg_a[ix] > mx_r) mx_r <= avg_a[ix];
          idx_r <= idx_r + 1'b1;
          if (last) state_r <= S_GSET;
        end
        S_GSET: begin
          guard_r <= 17'(clamp) + 17'(cfg.guard_margin);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r.chosen_valid   <= cv_r;
            out_r.chosen_task    <= curv_r ? cur_r : '0;
            out_r.delta_time     <= curv_r ? delta_a[ix] : 32'd0;
            out_r.waiting_count  <= (item_r.opcode == OP_SCHED) ? wait_r : 5'd0;
            out_r.load_percent   <= load_r;
            out_r.guard_interval <= guard_r;
            out_valid_r          <= 1'b1;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/aging_priority_task_scheduler.sv =====
// Aging priority task scheduler.
// in_valid/in_ready/in_data: one command per transfer (configure task,
// schedule pass, execution time report, system update). A two-entry queue
// takes commands while the sequencer is busy.
// out_valid/out_ready/out_data: exactly one result per command, in order.
// cfg_valid/cfg_ready/cfg_index/cfg_data: register writes, always ready;
// write only while the block is idle.
// Configure and report commands update the task table directly; a system
// update divides for the load when passes were counted, then scans the
// tasks for the guard interval; a schedule pass scans all task due times,
// then, per enabled task as needed, uses the one-bit-per-cycle restoring
// divider shared by all tasks. One command is worked at a time.
// Reset: all tasks disabled, periods 100, no current task, guard interval
// 300, registers at 10/300/25/100.
// When out_ready is low the result is held in the output register; the
// queue keeps accepting until it is full.
module aging_priority_task_scheduler import apts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg_r;
  logic q_valid;
  logic q_ready;
  in_t  q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.guard_min    <= 16'd10;
      cfg_r.guard_max    <= 16'd300;
      cfg_r.guard_margin <= 16'd25;
      cfg_r.min_period   <= 16'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GUARD_MIN:    cfg_r.guard_min    <= cfg_data;
        REG_GUARD_MAX:    cfg_r.guard_max    <= cfg_data;
        REG_GUARD_MARGIN: cfg_r.guard_margin <= cfg_data;
        REG_MIN_PERIOD:   cfg_r.min_period   <= cfg_data;
        default:          cfg_r.min_period   <= cfg_data;
      endcase
    end
  end

  apts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  apts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
